// ===== rtl/hcp_pkg.sv =====
`default_nettype none

package hcp_pkg;

  // coordinate format
  localparam int CW = 16;
  localparam int DW = CW + 1;
  localparam int SW = 17;
  localparam logic [SW-1:0] S_ONE = SW'(1) << (SW - 1);

  // square roots: tangent length is sqrt(|D|^2 * 2^20)
  localparam int TVW = 2 * CW + 20;
  localparam int TLW = CW + 10;
  localparam int LW  = CW + 1;

  // rescale divider
  localparam int QW = LW;
  localparam int TW = QW + 1;
  localparam int NW = CW + LW + 11;

  // basis and sum of products
  localparam int HW  = 32;
  localparam int BW  = 52;
  localparam int HSH = 18;
  localparam int PW  = HW + TW;
  localparam int AW  = PW + 2;
  localparam int RSH = 30;
  localparam int VW  = AW - RSH;

  localparam logic signed [VW-1:0] MAXV = VW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] MINV = -VW'(64'sd1 <<< (CW - 1));

  // stage map
  localparam int ST_SUMSQ = 1;
  localparam int ST_S3    = 2;
  localparam int ST_BASIS = 3;
  localparam int ST_SQ0   = 2;
  localparam int ST_MAG   = ST_SQ0 + TLW;
  localparam int ST_DIV0  = ST_MAG + 1;
  localparam int ST_MUL   = ST_DIV0 + QW;
  localparam int ST_SUM   = ST_MUL + 1;
  localparam int ST_OUT   = ST_SUM + 1;
  localparam int NST      = ST_OUT + 1;

endpackage

`default_nettype wire

// ===== rtl/hcp_in_if.sv =====
`default_nettype none

interface hcp_in_if
  import hcp_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [3*CW-1:0]   start_point;
  logic [3*CW-1:0]   start_tangent;
  logic [3*CW-1:0]   end_point;
  logic [3*CW-1:0]   end_tangent;
  logic [SW-1:0]     curve_param;

  modport source (
    output valid, start_point, start_tangent, end_point, end_tangent, curve_param,
    input  ready
  );
  modport sink (
    input  valid, start_point, start_tangent, end_point, end_tangent, curve_param,
    output ready
  );
endinterface

interface hcp_out_if
  import hcp_pkg::*;
  ;
  logic            valid;
  logic            ready;
  logic [3*CW-1:0] curve_point;
  logic            saturated;

  modport source (output valid, curve_point, saturated, input ready);
  modport sink   (input valid, curve_point, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/hermite_curve_point.sv =====
// Cubic Hermite point in 3D, one point per beat.
// in_ch (sink): two end points, two tangent directions and s, all in one beat.
// out_ch (source): the interpolated point and a flag set when any component
// was clipped to the coordinate range.
// Both channels use valid/ready; a beat moves when both are high.
// Throughput: one beat per cycle while the receiver does not stall. The square
// roots of the chord and tangent lengths take 26 one-bit steps and the rescale
// divider 17 one-bit steps, each a pipeline stage of its own.
// Every stage has a valid bit and its own load enable; a stage loads whenever
// it is empty or the stage after it moves, so bubbles close up and input is
// still taken during a receiver stall for as long as any stage is empty.
// A stall holds each occupied stage with no empty stage after it; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline; payload is not cleared.
`default_nettype none

module hermite_curve_point
  import hcp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  hcp_in_if.sink      in_ch,
  hcp_out_if.source   out_ch
);

  typedef struct packed {
    logic [TVW:0]     rem;
    logic [TLW-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [NW-1:0]    rem;
    logic [QW-1:0]    q;
  } dv_t;

  typedef struct packed {
    logic [2:0][CW-1:0]        p0;
    logic [2:0][CW-1:0]        p1;
    logic [1:0][2:0][CW-1:0]   dt;
    logic [2:0][2*DW-1:0]      dsq;
    logic [1:0][2:0][2*CW-1:0] tsq;
    logic [SW-1:0]             s;
    logic [2*SW-1:0]           s2;
    logic [2*SW-1:0]           s3h;
    logic [2*SW-1:0]           s3l;
    logic [3*SW-1:0]           s3;
    logic [3:0][HW-1:0]        h;
    sq_t                       ls;
    sq_t [1:0]                 ts;
    dv_t [1:0][2:0]            dv;
    logic [2:0][3:0][PW-1:0]   prod;
    logic [2:0][AW-1:0]        acc;
    logic [3*CW-1:0]           cp;
    logic                      sat;
  } item_t;

  function automatic sq_t sqrt_step(sq_t x, int i);
    sq_t          y;
    logic [TVW:0] trial;
    y = x;
    trial = ((TVW+1)'(x.root) << (i + 1)) + ((TVW+1)'(1) << (2 * i));
    if (x.rem >= trial) begin
      y.rem  = x.rem - trial;
      y.root = x.root | (TLW'(1) << i);
    end
    return y;
  endfunction

  function automatic dv_t div_step(dv_t x, logic [TLW-1:0] den, int i);
    dv_t           y;
    logic [NW-1:0] sub;
    y = x;
    sub = NW'(den) << i;
    if (x.rem >= sub) begin
      y.rem = x.rem - sub;
      y.q   = x.q | (QW'(1) << i);
    end
    return y;
  endfunction

  function automatic item_t load(
    logic [3*CW-1:0] sp, logic [3*CW-1:0] st, logic [3*CW-1:0] ep,
    logic [3*CW-1:0] et, logic [SW-1:0] cprm
  );
    item_t                    y;
    logic signed [DW-1:0]     df;
    logic signed [2*DW-1:0]   dm;
    logic signed [CW-1:0]     tc;
    logic signed [2*CW-1:0]   tm;
    y = '0;
    for (int c = 0; c < 3; c++) begin
      y.p0[c]    = sp[c*CW +: CW];
      y.p1[c]    = ep[c*CW +: CW];
      y.dt[0][c] = st[c*CW +: CW];
      y.dt[1][c] = et[c*CW +: CW];
      df = $signed({ep[c*CW+CW-1], ep[c*CW +: CW]}) - $signed({sp[c*CW+CW-1], sp[c*CW +: CW]});
      dm = df * df;
      y.dsq[c] = dm;
    end
    for (int j = 0; j < 2; j++) begin
      for (int c = 0; c < 3; c++) begin
        tc = $signed(y.dt[j][c]);
        tm = tc * tc;
        y.tsq[j][c] = tm;
      end
    end
    y.s  = (cprm > S_ONE) ? S_ONE : cprm;
    y.s2 = y.s * y.s;
    return y;
  endfunction

  function automatic item_t advance(item_t x, int k);
    item_t                  y;
    logic signed [BW-1:0]   s3e;
    logic signed [BW-1:0]   s2e;
    logic signed [BW-1:0]   s1e;
    logic signed [BW-1:0]   one;
    logic signed [BW-1:0]   hr [4];
    logic [CW-1:0]          mag;
    logic [CW+LW-1:0]       mp;
    logic signed [TW-1:0]   tv [2];
    logic signed [HW-1:0]   hs [4];
    logic signed [PW-1:0]   pr;
    logic signed [AW-1:0]   a;
    logic signed [VW-1:0]   vr;
    logic signed [CW-1:0]   vo;
    y = x;
    if (k == ST_SUMSQ) begin
      y.ls.rem  = (TVW+1)'(x.dsq[0]) + (TVW+1)'(x.dsq[1]) + (TVW+1)'(x.dsq[2]);
      y.ls.root = '0;
      for (int j = 0; j < 2; j++) begin
        y.ts[j].rem  = ((TVW+1)'(x.tsq[j][0]) + (TVW+1)'(x.tsq[j][1])
                       + (TVW+1)'(x.tsq[j][2])) << 20;
        y.ts[j].root = '0;
      end
      y.s3h = x.s * x.s2[2*SW-1:SW];
      y.s3l = x.s * x.s2[SW-1:0];
    end
    if (k == ST_S3) begin
      y.s3 = ((3*SW)'(x.s3h) << SW) + (3*SW)'(x.s3l);
    end
    if (k == ST_BASIS) begin
      s3e = $signed(BW'(x.s3));
      s2e = $signed(BW'(x.s2) << 16);
      s1e = $signed(BW'(x.s) << 32);
      one = $signed(BW'(1) << 48);
      hr[0] = (s3e <<< 1) - (s2e + (s2e <<< 1)) + one;
      hr[1] = (s2e + (s2e <<< 1)) - (s3e <<< 1);
      hr[2] = s3e - (s2e <<< 1) + s1e;
      hr[3] = s3e - s2e;
      for (int b = 0; b < 4; b++) begin
        hr[b] = hr[b] + $signed(BW'(1) << (HSH - 1));
        y.h[b] = hr[b][HSH+HW-1:HSH];
      end
    end
    if (k >= ST_SQ0 && k < ST_MAG) begin
      y.ls = sqrt_step(x.ls, TLW - 1 - (k - ST_SQ0));
      for (int j = 0; j < 2; j++) begin
        y.ts[j] = sqrt_step(x.ts[j], TLW - 1 - (k - ST_SQ0));
      end
    end
    if (k == ST_MAG) begin
      for (int j = 0; j < 2; j++) begin
        for (int c = 0; c < 3; c++) begin
          mag = x.dt[j][c][CW-1] ? (~x.dt[j][c] + CW'(1)) : x.dt[j][c];
          mp  = mag * x.ls.root[LW-1:0];
          y.dv[j][c].rem = (NW'(mp) << 10) + NW'(x.ts[j].root >> 1);
          y.dv[j][c].q   = '0;
        end
      end
    end
    if (k >= ST_DIV0 && k < ST_MUL) begin
      for (int j = 0; j < 2; j++) begin
        for (int c = 0; c < 3; c++) begin
          y.dv[j][c] = div_step(x.dv[j][c], x.ts[j].root, QW - 1 - (k - ST_DIV0));
        end
      end
    end
    if (k == ST_MUL) begin
      for (int b = 0; b < 4; b++) begin
        hs[b] = $signed(x.h[b]);
      end
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 2; j++) begin
          // zero-length tangent gives a zero tangent
          if (x.ts[j].root == '0) begin
            tv[j] = '0;
          end else if (x.dt[j][c][CW-1]) begin
            tv[j] = -$signed(TW'(x.dv[j][c].q));
          end else begin
            tv[j] = $signed(TW'(x.dv[j][c].q));
          end
        end
        pr = hs[0] * $signed(x.p0[c]);
        y.prod[c][0] = pr;
        pr = hs[1] * $signed(x.p1[c]);
        y.prod[c][1] = pr;
        pr = hs[2] * tv[0];
        y.prod[c][2] = pr;
        pr = hs[3] * tv[1];
        y.prod[c][3] = pr;
      end
    end
    if (k == ST_SUM) begin
      for (int c = 0; c < 3; c++) begin
        a = $signed(x.prod[c][0]) + $signed(x.prod[c][1])
          + $signed(x.prod[c][2]) + $signed(x.prod[c][3]);
        y.acc[c] = a;
      end
    end
    if (k == ST_OUT) begin
      y.sat = 1'b0;
      for (int c = 0; c < 3; c++) begin
        a  = $signed(x.acc[c]) + $signed(AW'(1) << (RSH - 1));
        vr = a[AW-1:RSH];
        if (vr > MAXV) begin
          vo    = CW'(MAXV);
          y.sat = 1'b1;
        end else if (vr < MINV) begin
          vo    = CW'(MINV);
          y.sat = 1'b1;
        end else begin
          vo = vr[CW-1:0];
        end
        y.cp[c*CW +: CW] = vo;
      end
    end
    return y;
  endfunction

  item_t          st_r   [NST];
  item_t          st_nxt [NST];
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_ch.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    st_nxt[0] = load(in_ch.start_point, in_ch.start_tangent, in_ch.end_point,
                     in_ch.end_tangent, in_ch.curve_param);
    for (int k = 1; k < NST; k++) begin
      st_nxt[k] = advance(st_r[k-1], k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // payload: advance only where a valid beat moves in
  always_ff @(posedge clk) begin
    if (rdy[0] && in_ch.valid) begin
      st_r[0] <= st_nxt[0];
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k] && v_r[k-1]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign in_ch.ready        = rdy[0];
  assign out_ch.valid       = v_r[NST-1];
  assign out_ch.curve_point = st_r[NST-1].cp;
  assign out_ch.saturated   = st_r[NST-1].sat;

endmodule

`default_nettype wire

// ===== dv/hcp_checker.sv =====
module hcp_checker
  import hcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hcp_in_if.sink      in_mon,
  hcp_out_if.sink     out_mon,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3*CW-1:0] point;
    logic            clipped;
  } curve_res_t;

  curve_res_t points_due[$];

  function automatic longint coord_of(logic [3*CW-1:0] word, int k);
    logic signed [CW-1:0] c;
    c = word[k*CW +: CW];
    return longint'(c);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // floor after adding half an LSB of the dropped part
  function automatic longint round_up_shift(longint v, int n);
    longint w;
    w = v + (longint'(1) <<< (n - 1));
    return w >>> n;
  endfunction

  // rescale a tangent direction to length len
  function automatic void rescale_tangent(logic [3*CW-1:0] word, longint unsigned len,
                                          output longint t[3]);
    longint d;
    longint unsigned sq;
    longint unsigned tl;
    longint unsigned mag;
    longint unsigned q;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      d = coord_of(word, k);
      sq += longint'(d * d);
    end
    tl = root_floor(sq << 20);
    for (int k = 0; k < 3; k++) begin
      d = coord_of(word, k);
      if (tl == 0) begin
        t[k] = 0;
      end else begin
        mag = longint'(d < 0 ? -d : d) * len * 1024;
        q = (mag + tl / 2) / tl;
        t[k] = d < 0 ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic curve_res_t hermite_point(logic [3*CW-1:0] p0w, logic [3*CW-1:0] d0w,
                                               logic [3*CW-1:0] p1w, logic [3*CW-1:0] d1w,
                                               logic [SW-1:0] sp);
    curve_res_t r;
    longint p0, p1, diff, s, s2, s3, h00, h01, h10, h11, acc, v;
    longint unsigned dd, len;
    longint t0[3];
    longint t1[3];
    dd = 0;
    for (int k = 0; k < 3; k++) begin
      diff = coord_of(p1w, k) - coord_of(p0w, k);
      dd += longint'(diff * diff);
    end
    len = root_floor(dd);
    rescale_tangent(d0w, len, t0);
    rescale_tangent(d1w, len, t1);
    s = sp > S_ONE ? longint'(S_ONE) : longint'(sp);
    s2 = s * s;
    s3 = s2 * s;
    h00 = round_up_shift(2 * s3 - 3 * (s2 <<< 16) + (longint'(1) <<< 48), 18);
    h01 = round_up_shift(-2 * s3 + 3 * (s2 <<< 16), 18);
    h10 = round_up_shift(s3 - 2 * (s2 <<< 16) + (s <<< 32), 18);
    h11 = round_up_shift(s3 - (s2 <<< 16), 18);
    r = '0;
    for (int k = 0; k < 3; k++) begin
      p0 = coord_of(p0w, k);
      p1 = coord_of(p1w, k);
      acc = h00 * p0 + h01 * p1 + h10 * t0[k] + h11 * t1[k];
      v = round_up_shift(acc, 30);
      if (v > 32767) begin
        v = 32767;
        r.clipped = 1'b1;
      end else if (v < -32768) begin
        v = -32768;
        r.clipped = 1'b1;
      end
      r.point[k*CW +: CW] = v[CW-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    curve_res_t want;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      points_due.delete();
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        points_due.push_back(hermite_point(in_mon.start_point, in_mon.start_tangent,
                                           in_mon.end_point, in_mon.end_tangent,
                                           in_mon.curve_param));
      if (out_mon.valid && out_mon.ready) begin
        if (points_due.size() == 0) begin
          $error("result beat with no point due");
          errs++;
        end else begin
          want = points_due.pop_front();
          if (want.point !== out_mon.curve_point) begin
            $error("curve_point: expected %h, got %h", want.point, out_mon.curve_point);
            errs++;
          end
          if (want.clipped !== out_mon.saturated) begin
            $error("saturated: expected %b, got %b", want.clipped, out_mon.saturated);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= points_due.size();
  end

endmodule

// ===== dv/hermite_curve_point_tb.sv =====
module hermite_curve_point_tb;
  import hcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 48;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   hold_off;
  bit   calm_rx;
  bit   calm_tx;
  bit   done;

  hcp_in_if  in_ch();
  hcp_out_if out_ch();

  hermite_curve_point uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  hcp_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                   .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return '0;
      3: return CW'($urandom_range(0, 15)) - 16'd8;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [3*CW-1:0] rand_vec();
    if ($urandom_range(0, 19) == 0) return '0;
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic logic [SW-1:0] rand_param();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return S_ONE;
      2: return SW'($urandom_range(65537, 131071));
      default: return SW'($urandom_range(0, 65536));
    endcase
  endfunction

  // offer one beat and hold it until accepted; idle gaps drop valid first
  task automatic send_beat(logic [3*CW-1:0] p0, logic [3*CW-1:0] d0,
                           logic [3*CW-1:0] p1, logic [3*CW-1:0] d1,
                           logic [SW-1:0] sp);
    if (!calm_tx && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 20) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.start_point   <= p0;
    in_ch.start_tangent <= d0;
    in_ch.end_point     <= p1;
    in_ch.end_tangent   <= d1;
    in_ch.curve_param   <= sp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else if (calm_rx) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 99) >= 20);
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles > STALL_LIMIT) begin
      $display("hermite_curve_point_tb: FAIL");
      $finish;
    end
  end

  initial begin
    done = 0;
    hold_off = 0;
    calm_rx = 0;
    calm_tx = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.start_point = '0;
    in_ch.start_tangent = '0;
    in_ch.end_point = '0;
    in_ch.end_tangent = '0;
    in_ch.curve_param = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero tangents, coincident points, s above one
    send_beat('0, '0, '0, '0, '0);
    send_beat({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h8000}}, 17'd32768);
    send_beat({3{16'h8000}}, {3{16'h8000}}, {3{16'h7fff}}, {3{16'h7fff}}, S_ONE);
    send_beat({3{16'h8000}}, 48'h0001_0000_0000, {3{16'h7fff}}, '0, 17'd21845);
    send_beat(48'h0000_0000_0100, '0, 48'h0000_0000_0100, 48'h0000_0100_0000, 17'd30000);
    send_beat(48'h0000_0000_0000, '0, 48'h0000_0000_0A00, '0, 17'd1);
    send_beat(48'h0100_0100_0100, 48'h0001_0001_0001, 48'h0200_0200_0200,
              48'hffff_ffff_ffff, 17'h1ffff);
    send_beat({3{16'hffff}}, 48'h7fff_8000_0001, {3{16'h0001}}, 48'h8000_7fff_ffff,
              17'd65537);
    send_beat({3{16'h8000}}, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, 17'd16384);
    send_beat({3{16'h7fff}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h7fff}}, 17'd49152);
    send_beat(48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'h0000_0000_0000,
              48'h5555_aaaa_5555, 17'h1aaaa);
    in_ch.valid <= 1'b0;

    // pause until every point has come back
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < 740; i++) begin
      if (i == 200) begin
        calm_rx = 1;
        calm_tx = 1;
      end
      if (i == 300) begin
        calm_rx = 0;
        calm_tx = 0;
        hold_off = 1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      send_beat(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_param());
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    done = 1;
    if (fail_count == 0 && pending == 0)
      $display("hermite_curve_point_tb: PASS");
    else
      $display("hermite_curve_point_tb: FAIL");
    $finish;
  end

endmodule
